// ===== rtl/core/bmm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared constants, command/status structs and controller states for the
// block median and mean core.
// ----------------------------------------------------------------------------
package bmm_pkg;

  // Sizing
  localparam int MAX_SAMPLES = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;

  // Port field widths
  localparam int SAMPLE_IN_BITS = 16;
  localparam int MEDIAN_BITS    = 17;
  localparam int MEAN_BITS      = 24;
  localparam int COUNT_BITS     = 11;

  // Derived widths
  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int DIVD_W = SUM_W + FRAC_BITS;
  localparam int BIT_W  = $clog2(SAMPLE_BITS);
  localparam int STEP_W = $clog2(DIVD_W + 1);

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_WAIT_DIV,
    ST_EMIT
  } bmm_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic store;        // take the input beat into the block
    logic sel_init;     // start a selection pass
    logic sel_hi;       // the pass started picks the upper middle rank
    logic issue;        // read the next stored sample
    logic decide;       // settle the current bit of the selection
    logic div_start;    // launch the mean division
    logic load_result;  // capture the result registers
    logic clear;        // empty the block
  } bmm_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_last;    // read address is on the last kept sample
    logic bit_zero;     // selection is on its lowest bit
    logic sel_hi;       // current pass is the upper middle rank
    logic cnt_odd;      // kept count is odd
    logic div_done;     // divider idle with quotient ready
  } bmm_stat_t;

endpackage

// ===== rtl/core/bmm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_div
// Restoring divider, one quotient bit per cycle, for the block mean.
// ----------------------------------------------------------------------------
module bmm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bmm_pkg::DIVD_W-1:0] dividend,
  input  logic [bmm_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [bmm_pkg::DIVD_W-1:0] quotient
);

  logic [bmm_pkg::STEP_W-1:0] steps;
  logic [bmm_pkg::DIVD_W-1:0] dq;
  logic [bmm_pkg::CNT_W-1:0]  rem;
  logic [bmm_pkg::CNT_W-1:0]  dsr;
  logic [bmm_pkg::CNT_W:0]    shifted;
  logic [bmm_pkg::CNT_W:0]    diff;
  logic                       fits;

  // Trial subtract of the shifted remainder
  always_comb begin
    shifted = {rem, dq[bmm_pkg::DIVD_W-1]};
    diff    = shifted - {1'b0, dsr};
    fits    = (shifted >= {1'b0, dsr});
  end

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= bmm_pkg::STEP_W'(bmm_pkg::DIVD_W);
    end else if (steps != '0) begin
      steps <= steps - 1'b1;
    end
  end

  // Shift quotient bits in over the dividend
  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (steps != '0) begin
      rem <= fits ? diff[bmm_pkg::CNT_W-1:0] : shifted[bmm_pkg::CNT_W-1:0];
      dq  <= {dq[bmm_pkg::DIVD_W-2:0], fits};
    end
  end

  assign done     = (steps == '0);
  assign quotient = dq;

endmodule

// ===== rtl/core/bmm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_datapath
// Sample store, running sum, bitwise rank selection over the store and the
// result registers.
// ----------------------------------------------------------------------------
module bmm_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  bmm_pkg::bmm_cmd_t                     cmd,
  output bmm_pkg::bmm_stat_t                    stat,
  input  logic signed [bmm_pkg::SAMPLE_IN_BITS-1:0] sample,
  output logic signed [bmm_pkg::MEDIAN_BITS-1:0] median_x2,
  output logic signed [bmm_pkg::MEAN_BITS-1:0]  mean_q8,
  output logic [bmm_pkg::COUNT_BITS-1:0]        count,
  output logic                                  overflow
);

  localparam int SB        = bmm_pkg::SAMPLE_BITS;
  localparam int BIT_IDX_W = bmm_pkg::BIT_W;

  // Block accumulation
  logic [bmm_pkg::SAMPLE_BITS-1:0] mem [bmm_pkg::MAX_SAMPLES];
  logic [bmm_pkg::CNT_W-1:0]       cnt;
  logic signed [bmm_pkg::SUM_W-1:0] sum;
  logic                            ovf;
  logic signed [SB-1:0]            smp;
  logic                            full;

  // Selection
  logic [bmm_pkg::ADDR_W-1:0] rd_addr;
  logic [SB-1:0]              rd_data;
  logic                       rd_vld;
  logic [bmm_pkg::CNT_W-1:0]  lt_count;
  logic [bmm_pkg::CNT_W-1:0]  rank;
  logic [BIT_IDX_W-1:0]       bit_idx;
  logic [SB-1:0]              prefix;
  logic [SB-1:0]              cand;
  logic [SB-1:0]              rd_ofs;
  logic [SB-1:0]              pick;
  logic                       sel_hi;
  logic signed [SB-1:0]       med_lo;
  logic signed [SB-1:0]       med_hi;
  logic signed [SB:0]         med_sum;

  // Mean
  logic [bmm_pkg::SUM_W-1:0]  sum_mag;
  logic [bmm_pkg::DIVD_W-1:0] dividend;
  logic [bmm_pkg::DIVD_W-1:0] quotient;
  logic [bmm_pkg::DIVD_W-1:0] mean_val;
  logic                       div_done;

  assign smp  = SB'(sample);
  assign full = (cnt == bmm_pkg::CNT_W'(bmm_pkg::MAX_SAMPLES));

  // Store the beat and keep count, sum and overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      sum <= '0;
      ovf <= 1'b0;
    end else if (cmd.clear) begin
      cnt <= '0;
      sum <= '0;
      ovf <= 1'b0;
    end else if (cmd.store) begin
      if (full) begin
        ovf <= 1'b1;
      end else begin
        cnt <= cnt + 1'b1;
        sum <= sum + bmm_pkg::SUM_W'(smp);
      end
    end
  end

  // Sample memory write port
  always_ff @(posedge clk) begin
    if (cmd.store && !full) begin
      mem[cnt[bmm_pkg::ADDR_W-1:0]] <= smp;
    end
  end

  // Sample memory read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  // Offset binary makes signed order an unsigned compare
  always_comb begin
    rd_ofs = {~rd_data[SB-1], rd_data[SB-2:0]};
    cand   = prefix | (SB'(1) << bit_idx);
    pick   = (lt_count <= rank) ? cand : prefix;
  end

  // Read valid tracks the registered read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.issue;
    end
  end

  // Scan the store once per bit and settle the bit
  always_ff @(posedge clk) begin
    if (cmd.decide && (bit_idx == '0)) begin
      med_hi <= {~pick[SB-1], pick[SB-2:0]};
      if (!sel_hi) begin
        med_lo <= {~pick[SB-1], pick[SB-2:0]};
      end
    end
    if (cmd.sel_init) begin
      rd_addr  <= '0;
      lt_count <= '0;
      prefix   <= '0;
      bit_idx  <= BIT_IDX_W'(SB - 1);
      sel_hi   <= cmd.sel_hi;
      rank     <= cmd.sel_hi ? (cnt >> 1) : ((cnt - 1'b1) >> 1);
    end else if (cmd.decide) begin
      rd_addr  <= '0;
      lt_count <= '0;
      prefix   <= pick;
      bit_idx  <= bit_idx - 1'b1;
    end else begin
      if (cmd.issue) begin
        rd_addr <= rd_addr + 1'b1;
      end
      if (rd_vld && (rd_ofs < cand)) begin
        lt_count <= lt_count + 1'b1;
      end
    end
  end

  // Mean division on the magnitude
  assign sum_mag  = sum[bmm_pkg::SUM_W-1] ? bmm_pkg::SUM_W'(-sum) : bmm_pkg::SUM_W'(sum);
  assign dividend = {sum_mag, {bmm_pkg::FRAC_BITS{1'b0}}};

  bmm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (cnt),
    .done     (div_done),
    .quotient (quotient)
  );

  assign mean_val = sum[bmm_pkg::SUM_W-1] ? (~quotient + 1'b1) : quotient;
  assign med_sum  = (SB + 1)'(med_lo) + (SB + 1)'(med_hi);

  // Capture the result
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      median_x2 <= bmm_pkg::MEDIAN_BITS'(med_sum);
      mean_q8   <= bmm_pkg::MEAN_BITS'(mean_val);
      count     <= bmm_pkg::COUNT_BITS'(cnt);
      overflow  <= ovf;
    end
  end

  // Status to the controller
  always_comb begin
    stat.scan_last = (rd_addr == bmm_pkg::ADDR_W'(cnt - 1'b1));
    stat.bit_zero  = (bit_idx == '0);
    stat.sel_hi    = sel_hi;
    stat.cnt_odd   = cnt[0];
    stat.div_done  = div_done;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= bmm_pkg::CNT_W'(bmm_pkg::MAX_SAMPLES))
    else $error("kept count beyond capacity");
`endif

endmodule

// ===== rtl/core/bmm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_ctrl
// Controller: collects beats, then sequences rank selection passes, the mean
// division and the one-cycle result strobe.
// ----------------------------------------------------------------------------
module bmm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               last,
  input  bmm_pkg::bmm_stat_t stat,
  output bmm_pkg::bmm_cmd_t  cmd,
  output logic               busy,
  output logic               done
);

  bmm_pkg::bmm_state_t state;
  bmm_pkg::bmm_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      bmm_pkg::ST_IDLE: begin
        if (start) begin
          cmd.store = 1'b1;
          if (last) begin
            state_next = bmm_pkg::ST_PREP;
          end
        end
      end
      bmm_pkg::ST_PREP: begin
        cmd.div_start = 1'b1;
        cmd.sel_init  = 1'b1;
        state_next    = bmm_pkg::ST_SCAN;
      end
      bmm_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.scan_last) begin
          state_next = bmm_pkg::ST_DRAIN;
        end
      end
      bmm_pkg::ST_DRAIN: begin
        state_next = bmm_pkg::ST_DECIDE;
      end
      bmm_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        if (!stat.bit_zero) begin
          state_next = bmm_pkg::ST_SCAN;
        end else if (!stat.sel_hi && !stat.cnt_odd) begin
          cmd.sel_init = 1'b1;
          cmd.sel_hi   = 1'b1;
          state_next   = bmm_pkg::ST_SCAN;
        end else begin
          state_next = bmm_pkg::ST_WAIT_DIV;
        end
      end
      bmm_pkg::ST_WAIT_DIV: begin
        if (stat.div_done) begin
          cmd.load_result = 1'b1;
          state_next      = bmm_pkg::ST_EMIT;
        end
      end
      bmm_pkg::ST_EMIT: begin
        cmd.clear  = 1'b1;
        state_next = bmm_pkg::ST_IDLE;
      end
      default: begin
        state_next = bmm_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != bmm_pkg::ST_IDLE);
  assign done = (state == bmm_pkg::ST_EMIT);

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");
  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("block stays busy after result");
  a_last_locks: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last) |=> (busy && !done))
    else $error("closing beat did not start the block computation");
`endif

endmodule

// ===== rtl/core/block_median_and_mean_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_median_and_mean_core
// Block median (doubled) and mean (Q8) of signed samples over a block
// closed by a beat marked last.
// ----------------------------------------------------------------------------
// Throughput: one sample beat per cycle while collecting; busy stays low.
// After the closing beat with n samples kept, done pulses once the rank search
//   is through: one selection pass for odd n and two for even n; each
//   bit of the rank search is one scan of the sample memory.
// The mean divider runs under the first selection pass.
// Reset clears count, sum, overflow and the controller; the receiver cannot
//   stall, so each result shows for exactly one cycle.
module block_median_and_mean_core (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  output logic                                      busy,
  input  logic signed [bmm_pkg::SAMPLE_IN_BITS-1:0] sample,
  input  logic                                      last,
  output logic                                      done,
  output logic signed [bmm_pkg::MEDIAN_BITS-1:0]    median_x2,
  output logic signed [bmm_pkg::MEAN_BITS-1:0]      mean_q8,
  output logic [bmm_pkg::COUNT_BITS-1:0]            count,
  output logic                                      overflow
);

  bmm_pkg::bmm_cmd_t  cmd;
  bmm_pkg::bmm_stat_t stat;

  // Sequencing
  bmm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .last  (last),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Storage and arithmetic
  bmm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .sample    (sample),
    .median_x2 (median_x2),
    .mean_q8   (mean_q8),
    .count     (count),
    .overflow  (overflow)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the block median and mean core. Sample beats go in
// through the start/busy handshake in blocks closed by a beat marked last.
// A scoreboard keeps its own copy of each block, works out the doubled
// median, the Q8 mean, the kept count and the overflow flag, and compares
// them with every done strobe. Directed blocks hit the field extremes, and
// random blocks follow, one of them past capacity.
// ----------------------------------------------------------------------------

typedef struct {
  logic signed [bmm_pkg::MEDIAN_BITS-1:0] median_x2;
  logic signed [bmm_pkg::MEAN_BITS-1:0]   mean_q8;
  logic [bmm_pkg::COUNT_BITS-1:0]         count;
  logic                                   overflow;
} block_stats_t;

class bmm_stats_board;
  int           kept[$];
  longint       kept_sum;
  bit           dropped;
  block_stats_t pending_stats[$];
  int           mismatches;

  // Keep one accepted beat; on a closing beat, predict the block result
  function void take_sample(logic signed [bmm_pkg::SAMPLE_IN_BITS-1:0] s, logic l);
    int           ord[$];
    int           i;
    int           j;
    int           key;
    int           n;
    longint       med;
    longint       avg;
    block_stats_t exp_stats;
    if (kept.size() < bmm_pkg::MAX_SAMPLES) begin
      kept.insert(kept.size(), int'(s));
      kept_sum += longint'(s);
    end else begin
      dropped = 1'b1;
    end
    if (!l) return;
    // Sort a copy of the block to find the middle ranks
    ord = kept;
    n = ord.size();
    for (i = 1; i < n; i++) begin
      key = ord[i];
      j = i;
      while (j > 0 && ord[j-1] > key) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = key;
    end
    if (n % 2 == 0) med = longint'(ord[n/2-1]) + longint'(ord[n/2]);
    else med = 2 * longint'(ord[n/2]);
    // Signed division truncates toward zero
    avg = (kept_sum * 256) / n;
    exp_stats.median_x2 = med[bmm_pkg::MEDIAN_BITS-1:0];
    exp_stats.mean_q8   = avg[bmm_pkg::MEAN_BITS-1:0];
    exp_stats.count     = n[bmm_pkg::COUNT_BITS-1:0];
    exp_stats.overflow  = dropped;
    pending_stats.insert(pending_stats.size(), exp_stats);
    // Start the next block empty
    kept.delete();
    kept_sum = 0;
    dropped  = 1'b0;
  endfunction

  // Compare one done strobe with the oldest predicted block
  function void check_stats(logic signed [bmm_pkg::MEDIAN_BITS-1:0] med,
                            logic signed [bmm_pkg::MEAN_BITS-1:0] avg,
                            logic [bmm_pkg::COUNT_BITS-1:0] cnt, logic ovf);
    block_stats_t e;
    if (pending_stats.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result with no block pending: median_x2=%0d mean_q8=%0d count=%0d ovf=%0b",
                 med, avg, cnt, ovf);
      return;
    end
    e = pending_stats.pop_front();
    if (med !== e.median_x2 || avg !== e.mean_q8 || cnt !== e.count || ovf !== e.overflow) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: exp median_x2=%0d mean_q8=%0d count=%0d ovf=%0b, got %0d %0d %0d %0b",
                 e.median_x2, e.mean_q8, e.count, e.overflow, med, avg, cnt, ovf);
    end
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_BEATS = 1350;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [bmm_pkg::SAMPLE_IN_BITS-1:0] sample = '0;
  logic last = 1'b0;
  logic busy;
  logic done;
  logic signed [bmm_pkg::MEDIAN_BITS-1:0] median_x2;
  logic signed [bmm_pkg::MEAN_BITS-1:0]   mean_q8;
  logic [bmm_pkg::COUNT_BITS-1:0]         count;
  logic                                   overflow;

  bmm_stats_board board;

  block_median_and_mean_core uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .sample    (sample),
    .last      (last),
    .done      (done),
    .median_x2 (median_x2),
    .mean_q8   (mean_q8),
    .count     (count),
    .overflow  (overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bound the run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // Check every done strobe
  always @(posedge clk) begin
    if (!rst && done) board.check_stats(median_x2, mean_q8, count, overflow);
  end

  // Idle length before a beat: mostly none, a few long
  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  // Draw a sample: full range, a tight cluster with repeats, or an extreme
  function automatic logic signed [15:0] draw_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 16'($urandom_range(0, 65535));
    if (r < 80) return 16'($urandom_range(0, 15) - 8);
    case ($urandom_range(0, 3))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  // Offer one beat and hold it until the block takes it
  task automatic send_beat(input logic signed [15:0] s, input logic l, input bit burst);
    int gap;
    gap = pick_gap(burst);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    sample <= s;
    last   <= l;
    do @(posedge clk); while (busy);
    board.take_sample(s, l);
  endtask

  // Send a whole block of given samples
  task automatic send_block(input int vals[$]);
    int k;
    for (k = 0; k < vals.size(); k++)
      send_beat(16'(vals[k]), k == vals.size() - 1, 1'b0);
  endtask

  initial begin
    int  sent;
    int  blk;
    int  long_at;
    int  len;
    int  k;
    bit  burst;
    board = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, even/odd counts, negative truncation, bit patterns
    send_block('{-32768});
    send_block('{32767});
    send_block('{32767, -32768});
    send_block('{-32768, -32768});
    send_block('{32767, 32767, 32767});
    send_block('{5, -3, 0});
    send_block('{-1, 0, 0});
    send_block('{21845, -21846, 7, 7});
    send_block('{3, 2, 1, 0, -1});

    // Random blocks, mostly short; one runs past capacity
    sent = 0;
    blk = 0;
    long_at = $urandom_range(3, 30);
    while (sent < RANDOM_BEATS) begin
      k = $urandom_range(0, 99);
      if (blk == long_at) len = bmm_pkg::MAX_SAMPLES + $urandom_range(1, 6);
      else if (k < 70) len = $urandom_range(1, 8);
      else if (k < 95) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 100);
      burst = ($urandom_range(0, 3) == 0);
      for (k = 0; k < len; k++) send_beat(draw_sample(), k == len - 1, burst);
      sent += len;
      blk++;
    end
    start <= 1'b0;

    // Drain outstanding blocks, then watch for stray strobes
    while (board.pending_stats.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/bmm_pkg.sv
rtl/core/bmm_div.sv
rtl/core/bmm_datapath.sv
rtl/core/bmm_ctrl.sv
rtl/core/block_median_and_mean_core.sv
verif/tb_top.sv
